// File: rtl/core/fcce_pkg.sv
package fcce_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned SCAN_W      = ADDR_W + 1;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned LIMIT_W     = 11;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned CMP_W       = WORD_W + 1;

  localparam logic [WORD_W-1:0]  EOC_WORD   = 16'hFFFF;
  localparam logic [LIMIT_W-1:0] SCAN_RESET = 11'd1000;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [CMP_W-1:0]   DEPTH_CMP  = CMP_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_BROKEN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ_WAIT,
    S_ALLOC,
    S_LINK,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_e;

  // APB register map
  localparam logic REG_SCAN_LIMIT = 1'b0;

endpackage

// File: rtl/core/fat16_cluster_chain_engine_unit.sv
// FAT16 cluster-chain table: 1024 next-cluster words in one single-port RAM.
// Input channel (valid/ready) takes one command per transfer: read, write,
// allocate or free-chain. Output channel (valid/ready) returns one result
// (status, data, freed_count) per command, in order.
// Path from input transfer to result in the output register, by command:
//   write: RAM written at the transfer, then S_RESP; read: S_READ_WAIT, S_RESP;
//   allocate: clusters scanned from cluster two to below the scan limit
//     (one RAM read per cycle, hit written back in the cycle the data returns),
//     then S_LINK when a previous cluster is linked, then S_RESP;
//   free-chain: per entry walked a read (at the transfer, then in S_FREE_RD)
//     and a clear in S_FREE_WR, sharing the single RAM port, then S_RESP.
// A new command is taken once the previous result has moved to the output
// register, so the next item can run while a result waits to be taken; if
// the receiver stalls with a result still pending, the engine holds and
// ready drops.
// After reset the table is cleared one entry a cycle, all 1024 entries,
// while ready stays low. scan_limit resets to 1000 and can be written over
// the APB port at any time (pready is tied high).
module fat16_cluster_chain_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [fcce_pkg::WORD_W-1:0]   cluster_i,
  input  logic [fcce_pkg::WORD_W-1:0]   value_i,
  input  logic                          link_enable_i,
  input  logic [fcce_pkg::WORD_W-1:0]   link_from_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [fcce_pkg::WORD_W-1:0]   data_o,
  output logic [fcce_pkg::COUNT_W-1:0]  freed_count_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fcce_pkg::*;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   cur_q, cur_d;
  logic [SCAN_W-1:0]   scan_q, scan_d;
  logic [SCAN_W-1:0]   lim_q, lim_d;
  logic                pend_q, pend_d;
  logic [ADDR_W-1:0]   pend_addr_q, pend_addr_d;
  logic                link_en_q, link_en_d;
  logic [ADDR_W-1:0]   link_from_q, link_from_d;
  logic [1:0]          res_status_q, res_status_d;
  logic [WORD_W-1:0]   res_data_q, res_data_d;
  logic [COUNT_W-1:0]  res_count_q, res_count_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_status_q, out_status_d;
  logic [WORD_W-1:0]   out_data_q, out_data_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic [LIMIT_W-1:0]  scan_limit_q, scan_limit_d;

  logic [WORD_W-1:0]   fat_mem [TABLE_DEPTH];
  logic [WORD_W-1:0]   mem_rdata_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [WORD_W-1:0]   mem_wdata;

  logic in_xfer, cl_ok, start_ok, from_ok, scan_hit, scan_more;
  logic next_eoc, next_ok, out_free, clr_last, cfg_wr;
  logic [SCAN_W-1:0] lim_start;

  // ---------------------------------------------------------------------------
  // conditions
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cl_ok      = {1'b0, cluster_i} < DEPTH_CMP;
  assign start_ok   = cl_ok && (cluster_i >= WORD_W'(2));
  assign from_ok    = ({1'b0, link_from_i} < DEPTH_CMP) && (link_from_i >= WORD_W'(2));
  assign scan_hit   = pend_q && (mem_rdata_q == '0);
  assign scan_more  = scan_q < lim_q;
  assign next_eoc   = (mem_rdata_q == EOC_WORD);
  assign next_ok    = ({1'b0, mem_rdata_q} < DEPTH_CMP) && (mem_rdata_q >= WORD_W'(2));
  assign out_free   = !out_valid_q || out_ready_i;
  assign clr_last   = (cur_q == ADDR_W'(TABLE_DEPTH - 1));
  assign lim_start  = ({{(CMP_W-LIMIT_W){1'b0}}, scan_limit_q} > DEPTH_CMP) ?
                      SCAN_W'(TABLE_DEPTH) : SCAN_W'(scan_limit_q);

  // ---------------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCAN_LIMIT);
  assign scan_limit_d = cfg_wr ? pwdata[LIMIT_W-1:0] : scan_limit_q;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SCAN_LIMIT) begin
      prdata = 32'(scan_limit_q);
    end
  end

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          unique case (cmd_i)
            CMD_READ:  state_d = cl_ok ? S_READ_WAIT : S_RESP;
            CMD_WRITE: state_d = S_RESP;
            CMD_ALLOC: state_d = (link_enable_i && !from_ok) ? S_RESP : S_ALLOC;
            CMD_FREE:  state_d = start_ok ? S_FREE_WR : S_RESP;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_READ_WAIT: state_d = S_RESP;
      S_ALLOC: begin
        if (scan_hit) begin
          state_d = link_en_q ? S_LINK : S_RESP;
        end else if (!scan_more) begin
          state_d = S_RESP;
        end
      end
      S_LINK:    state_d = S_RESP;
      S_FREE_RD: state_d = S_FREE_WR;
      S_FREE_WR: begin
        if (next_eoc || !next_ok) state_d = S_RESP;
        else                      state_d = S_FREE_RD;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and RAM control
  always_comb begin
    cur_d        = cur_q;
    scan_d       = scan_q;
    lim_d        = lim_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    link_en_d    = link_en_q;
    link_from_d  = link_from_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_count_d  = res_count_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_count_d  = out_count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    mem_addr     = cur_q;
    mem_wdata    = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        cur_d  = cur_q + ADDR_W'(1);
      end
      S_IDLE: begin
        mem_addr = cluster_i[ADDR_W-1:0];
        if (in_xfer) begin
          res_status_d = STAT_OK;
          res_data_d   = '0;
          res_count_d  = '0;
          link_en_d    = link_enable_i;
          link_from_d  = link_from_i[ADDR_W-1:0];
          cur_d        = cluster_i[ADDR_W-1:0];
          scan_d       = SCAN_W'(2);
          lim_d        = lim_start;
          unique case (cmd_i)
            CMD_READ: begin
              if (!cl_ok) res_status_d = STAT_RANGE;
            end
            CMD_WRITE: begin
              if (cl_ok) begin
                mem_we    = 1'b1;
                mem_wdata = value_i;
              end else begin
                res_status_d = STAT_RANGE;
              end
            end
            CMD_ALLOC: begin
              if (link_enable_i && !from_ok) res_status_d = STAT_RANGE;
            end
            CMD_FREE: begin
              if (!start_ok) res_status_d = STAT_RANGE;
            end
            default: ;
          endcase
        end
      end
      S_READ_WAIT: res_data_d = mem_rdata_q;
      S_ALLOC: begin
        if (scan_hit) begin
          mem_we     = 1'b1;
          mem_addr   = pend_addr_q;
          mem_wdata  = EOC_WORD;
          res_data_d = WORD_W'(pend_addr_q);
        end else if (scan_more) begin
          // one read in flight while the previous word is checked
          mem_addr    = scan_q[ADDR_W-1:0];
          pend_d      = 1'b1;
          pend_addr_d = scan_q[ADDR_W-1:0];
          scan_d      = scan_q + SCAN_W'(1);
        end else begin
          res_status_d = STAT_NOFREE;
        end
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_addr  = link_from_q;
        mem_wdata = res_data_q;
      end
      S_FREE_RD: mem_addr = cur_q;
      S_FREE_WR: begin
        mem_we   = 1'b1;
        mem_addr = cur_q;
        if (res_count_q != COUNT_MAX) res_count_d = res_count_q + COUNT_W'(1);
        if (!next_eoc && !next_ok) res_status_d = STAT_BROKEN;
        cur_d = mem_rdata_q[ADDR_W-1:0];
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          out_count_d  = res_count_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // table RAM, read-first, one port
  always_ff @(posedge clk_i) begin
    if (mem_we) fat_mem[mem_addr] <= mem_wdata;
    mem_rdata_q <= fat_mem[mem_addr];
  end

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cur_q        <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      scan_limit_q <= SCAN_RESET;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      scan_limit_q <= scan_limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    lim_q        <= lim_d;
    pend_addr_q  <= pend_addr_d;
    link_en_q    <= link_en_d;
    link_from_q  <= link_from_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_count_q  <= res_count_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign data_o        = out_data_q;
  assign freed_count_o = out_count_q;

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 200;

  typedef struct packed {
    cmd_e              cmd;
    logic [WORD_W-1:0] cluster;
    logic [WORD_W-1:0] value;
    logic              link_en;
    logic [WORD_W-1:0] link_from;
  } fat_cmd_t;

  typedef struct packed {
    status_e            status;
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] freed;
  } fat_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  fat_cmd_t    tx_now = '0;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic                in_ready_o;
  logic                out_valid_o;
  logic [1:0]          status_o;
  logic [WORD_W-1:0]   data_o;
  logic [COUNT_W-1:0]  freed_count_o;
  logic [31:0]         prdata;
  logic                apb_ready;

  // shadow of the block: table contents and scan limit
  logic [WORD_W-1:0]   fat_shadow [0:TABLE_DEPTH-1];
  logic [LIMIT_W-1:0]  scan_shadow = SCAN_RESET;

  fat_cmd_t    cmd_backlog [$];
  fat_result_t results_due [$];
  fat_result_t head_due;

  int unsigned queued_cmds = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          in_taken = 1'b0;
  bit          steady = 1'b0;
  bit          hold_go = 1'b0;
  bit          rx_hold = 1'b0;

  fat16_cluster_chain_engine_unit uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .cmd_i         (tx_now.cmd),
    .cluster_i     (tx_now.cluster),
    .value_i       (tx_now.value),
    .link_enable_i (tx_now.link_en),
    .link_from_i   (tx_now.link_from),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .status_o      (status_o),
    .data_o        (data_o),
    .freed_count_o (freed_count_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (apb_ready)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (fat_shadow[n]) fat_shadow[n] = '0;
  end

  function automatic bit chain_ok(input int unsigned c);
    return c >= 2 && c < TABLE_DEPTH;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Apply one accepted command to the shadow table and queue its result.
  task automatic apply_fat_cmd(input fat_cmd_t c);
    fat_result_t r;
    int unsigned cur, nxt, top, idx;
    bit done;
    r.status = STAT_OK;
    r.data = '0;
    r.freed = '0;
    case (c.cmd)
      CMD_READ: begin
        if (c.cluster < TABLE_DEPTH) r.data = fat_shadow[c.cluster];
        else r.status = STAT_RANGE;
      end
      CMD_WRITE: begin
        if (c.cluster < TABLE_DEPTH) fat_shadow[c.cluster] = c.value;
        else r.status = STAT_RANGE;
      end
      CMD_ALLOC: begin
        top = (scan_shadow > TABLE_DEPTH) ? TABLE_DEPTH : scan_shadow;
        if (c.link_en && !chain_ok(c.link_from)) begin
          r.status = STAT_RANGE;
        end else begin
          r.status = STAT_NOFREE;
          for (idx = 2; idx < top && r.status == STAT_NOFREE; idx++) begin
            if (fat_shadow[idx] == '0) begin
              fat_shadow[idx] = EOC_WORD;
              // a self link overwrites the end marker just set
              if (c.link_en) fat_shadow[c.link_from] = WORD_W'(idx);
              r.status = STAT_OK;
              r.data = WORD_W'(idx);
            end
          end
        end
      end
      CMD_FREE: begin
        if (!chain_ok(c.cluster)) begin
          r.status = STAT_RANGE;
        end else begin
          cur = c.cluster;
          done = 1'b0;
          while (!done) begin
            nxt = fat_shadow[cur];
            fat_shadow[cur] = '0;
            if (r.freed != COUNT_MAX) r.freed++;
            if (nxt == EOC_WORD) begin
              done = 1'b1;
            end else if (!chain_ok(nxt)) begin
              // also catches loops: a cleared entry reads back as zero
              r.status = STAT_BROKEN;
              done = 1'b1;
            end else begin
              cur = nxt;
            end
          end
        end
      end
    endcase
    results_due.push_back(r);
  endtask

  // command driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
        tx_now <= cmd_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    out_ready <= !rx_hold && (steady || $urandom_range(99) >= 20);
  end

  // monitor: result check first, then prediction for the command taken
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      if (rst_n && out_valid_o && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d with nothing due: status %0d data %h freed %0d",
                                  results_seen, status_o, data_o, freed_count_o));
        end else begin
          head_due = results_due.pop_front();
          if (status_o !== head_due.status || data_o !== head_due.data ||
              freed_count_o !== head_due.freed)
            flag_mismatch($sformatf(
              "result %0d got/exp: status %0d/%0d data %h/%h freed %0d/%0d",
              results_seen, status_o, head_due.status, data_o, head_due.data,
              freed_count_o, head_due.freed));
        end
      end
      in_taken = rst_n && in_valid && in_ready_o;
      if (in_taken) apply_fat_cmd(tx_now);
    end
  end

  // long receiver hold-off so the engine backs up and drops ready
  initial begin
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic queue_cmd(input cmd_e op, input logic [WORD_W-1:0] cl,
                           input logic [WORD_W-1:0] val, input logic len,
                           input logic [WORD_W-1:0] from);
    fat_cmd_t c;
    c.cmd = op;
    c.cluster = cl;
    c.value = val;
    c.link_en = len;
    c.link_from = from;
    cmd_backlog.push_back(c);
    queued_cmds++;
  endtask

  function automatic logic [WORD_W-1:0] rand_cluster();
    case ($urandom_range(3))
      0, 1:    return WORD_W'($urandom_range(127));
      2:       return WORD_W'($urandom_range(TABLE_DEPTH - 1));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(3))
      0:       return EOC_WORD;
      1:       return WORD_W'($urandom_range(127));
      2:       return WORD_W'($urandom_range(TABLE_DEPTH - 1));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Build a short chain by writes, maybe break or loop it, maybe extend it by a
  // linked allocate, read parts back, then free it from its head.
  task automatic queue_chain_run();
    logic [WORD_W-1:0] links [8];
    int k, i, j, pick;
    bit dup;
    k = $urandom_range(1, 8);
    for (i = 0; i < k; i++) begin
      do begin
        links[i] = WORD_W'($urandom_range(2, 127));
        dup = 1'b0;
        for (j = 0; j < i; j++) if (links[j] == links[i]) dup = 1'b1;
      end while (dup);
    end
    for (i = 0; i < k; i++)
      queue_cmd(CMD_WRITE, links[i], (i == k - 1) ? EOC_WORD : links[i + 1],
                1'($urandom_range(1)), WORD_W'($urandom));
    if ($urandom_range(4) == 0) begin
      pick = $urandom_range(k - 1);
      case ($urandom_range(3))
        0:       queue_cmd(CMD_WRITE, links[pick], '0, 1'b0, '0);
        1:       queue_cmd(CMD_WRITE, links[pick], WORD_W'(1), 1'b1, '1);
        2:       queue_cmd(CMD_WRITE, links[pick], links[0], 1'b0, '0);
        default: queue_cmd(CMD_WRITE, links[pick],
                           WORD_W'($urandom_range(TABLE_DEPTH, 16'hFFFE)), 1'b1, '1);
      endcase
    end
    if ($urandom_range(1))
      queue_cmd(CMD_ALLOC, WORD_W'($urandom), WORD_W'($urandom), 1'b1, links[k - 1]);
    repeat ($urandom_range(2))
      queue_cmd(CMD_READ, links[$urandom_range(k - 1)], WORD_W'($urandom),
                1'($urandom_range(1)), WORD_W'($urandom));
    queue_cmd(CMD_FREE, links[0], WORD_W'($urandom), 1'($urandom_range(1)),
              WORD_W'($urandom));
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned target;
    target = queued_cmds + n;
    while (queued_cmds < target) begin
      if ($urandom_range(99) < 60) queue_chain_run();
      else queue_cmd(cmd_e'($urandom_range(3)), rand_cluster(), rand_word(),
                     1'($urandom_range(1)), rand_cluster());
    end
  endtask

  task automatic drain_all();
    while (cmd_backlog.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  // write scan_limit over APB once the engine is idle, then read it back
  task automatic set_scan_limit(input logic [LIMIT_W-1:0] lim);
    drain_all();
    scan_shadow = lim;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_SCAN_LIMIT, 2'b00};
    pwdata <= 32'(lim);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[LIMIT_W-1:0] !== lim)
      flag_mismatch($sformatf("scan_limit read back %h, wrote %h", prdata, lim));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, entries 0 and 1, range errors, links, chains
    queue_cmd(CMD_READ,  16'd0,    16'h0000, 1'b0, 16'h0000);
    queue_cmd(CMD_WRITE, 16'd0,    EOC_WORD, 1'b1, 16'hFFFF);
    queue_cmd(CMD_WRITE, 16'd1,    16'h1234, 1'b0, 16'h0000);
    queue_cmd(CMD_READ,  16'd0,    16'hFFFF, 1'b1, 16'hFFFF);
    queue_cmd(CMD_READ,  16'd1,    16'h0000, 1'b0, 16'h0000);
    queue_cmd(CMD_WRITE, 16'd1023, 16'hA5A5, 1'b0, 16'h0000);
    queue_cmd(CMD_READ,  16'd1023, 16'h0000, 1'b0, 16'h0000);
    queue_cmd(CMD_READ,  16'd1024, 16'h0000, 1'b0, 16'h0000);
    queue_cmd(CMD_WRITE, 16'hFFFF, 16'h5A5A, 1'b1, 16'hFFFF);
    queue_cmd(CMD_READ,  16'hFFFF, 16'hFFFF, 1'b0, 16'h0000);
    queue_cmd(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF);
    queue_cmd(CMD_ALLOC, 16'd0,    16'd0,    1'b1, 16'd2);
    queue_cmd(CMD_ALLOC, 16'd0,    16'd0,    1'b1, 16'd1);
    queue_cmd(CMD_ALLOC, 16'd0,    16'd0,    1'b1, 16'd1024);
    queue_cmd(CMD_ALLOC, 16'd0,    16'd0,    1'b1, 16'd4);
    queue_cmd(CMD_FREE,  16'd4,    16'd0,    1'b0, 16'd0);
    queue_cmd(CMD_FREE,  16'd2,    16'd0,    1'b0, 16'd0);
    queue_cmd(CMD_FREE,  16'd1,    16'd0,    1'b0, 16'd0);
    queue_cmd(CMD_FREE,  16'd1024, 16'd0,    1'b0, 16'd0);
    queue_cmd(CMD_WRITE, 16'd10,   16'd1,    1'b0, 16'd0);
    queue_cmd(CMD_FREE,  16'd10,   16'd0,    1'b0, 16'd0);
    queue_cmd(CMD_WRITE, 16'd11,   16'd2000, 1'b0, 16'd0);
    queue_cmd(CMD_FREE,  16'd11,   16'd0,    1'b0, 16'd0);
    queue_cmd(CMD_WRITE, 16'd1023, EOC_WORD, 1'b0, 16'd0);
    queue_cmd(CMD_FREE,  16'd1023, 16'd0,    1'b0, 16'd0);

    // top of range: one long chain, a deep scan, then random under back-pressure
    set_scan_limit(11'd1024);
    for (i = 2; i <= 521; i++)
      queue_cmd(CMD_WRITE, WORD_W'(i), (i == 521) ? EOC_WORD : WORD_W'(i + 1), 1'b0, '0);
    queue_cmd(CMD_ALLOC, 16'd0, 16'd0, 1'b1, 16'd521);
    queue_cmd(CMD_READ,  16'd521, 16'd0, 1'b0, 16'd0);
    queue_cmd(CMD_FREE,  16'd2, 16'd0, 1'b0, 16'd0);
    hold_go = 1'b1;
    queue_random(150);

    set_scan_limit(11'd3);
    queue_random(150);

    // searches nothing
    set_scan_limit(11'd2);
    queue_random(80);

    // above the table, with no idling on either side
    set_scan_limit(11'd2047);
    steady = 1'b1;
    queue_random(150);
    drain_all();
    steady = 1'b0;

    set_scan_limit(11'd40);
    queue_random(150);

    repeat (2) begin
      set_scan_limit(LIMIT_W'($urandom_range(3, 1024)));
      queue_random(110);
    end

    drain_all();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
